// ===== src/mstt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mstt_pkg
// Shared codes, constants and controller/datapath interface types for the
// timer table.
// ----------------------------------------------------------------------------
package mstt_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int ID_BITS_DEF   = 16;
    localparam int TIME_BITS_DEF = 32;

    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_RESTART = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_CYCLIC  = 3'd3;
    localparam logic [2:0] OP_QUERY   = 3'd4;
    localparam logic [2:0] OP_TICK    = 3'd5;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_EXPIRY = 2'd1;
    localparam logic [1:0] KIND_IDLE   = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture request payload
        logic clr_scan;  // zero slot pointer and search flags
        logic scan;      // examine current slot (search pass)
        logic tick;      // examine and advance current slot (tick pass)
        logic step;      // advance slot pointer
        logic apply;     // apply command to found or free slot
    } mstt_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_last; // pointer sits on the final slot
        logic expire;    // current slot expires on this tick
        logic tick_op;   // captured request is a tick
    } mstt_sts_t;

endpackage
`default_nettype wire

// ===== src/mstt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mstt_ctrl
// Sequencer: captures a request, walks the slots one per cycle, pausing a
// tick while a result waits, and hands each result to the output register.
// ----------------------------------------------------------------------------
module mstt_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               out_free,
    input  wire mstt_pkg::mstt_sts_t sts,
    output mstt_pkg::mstt_cmd_t     cmd,
    output logic                    emit_status,
    output logic                    emit_expiry,
    output logic                    emit_idle
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_APPLY = 3'd2;
    localparam logic [2:0] ST_TICK  = 3'd3;

    logic [2:0] state_reg, state_next;
    logic       hit_reg, hit_next;

    // Sequence the request
    always_comb begin
        state_next  = state_reg;
        hit_next    = hit_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        emit_status = 1'b0;
        emit_expiry = 1'b0;
        emit_idle   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load     = 1'b1;
                    cmd.clr_scan = 1'b1;
                    hit_next     = 1'b0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.tick_op) begin
                    state_next = ST_TICK;
                end else begin
                    cmd.scan = 1'b1;
                    cmd.step = 1'b1;
                    if (sts.scan_last) state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                // a tick only flushes its held expiry here
                if (out_free) begin
                    cmd.apply   = !sts.tick_op;
                    emit_status = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_TICK: begin
                // stall the walk while an expiry waits for the output
                if (out_free || !sts.expire) begin
                    cmd.tick = 1'b1;
                    cmd.step = 1'b1;
                    if (sts.expire) begin
                        emit_expiry = 1'b1;
                        hit_next    = 1'b1;
                    end
                    if (sts.scan_last) begin
                        if (sts.expire || hit_reg) begin
                            state_next = ST_APPLY; // flush trailing marker
                        end else if (out_free) begin
                            emit_idle  = 1'b1;
                            state_next = ST_IDLE;
                        end else begin
                            cmd.tick = 1'b0;
                            cmd.step = 1'b0;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            hit_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            hit_reg   <= hit_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/mstt_path.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mstt_path
// Slot store, scan pointer, match and expiry logic, and output register.
// ----------------------------------------------------------------------------
module mstt_path #(
    parameter int SLOTS     = mstt_pkg::SLOTS_DEF,
    parameter int ID_BITS   = mstt_pkg::ID_BITS_DEF,
    parameter int TIME_BITS = mstt_pkg::TIME_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [2:0]          s_operation,
    input  wire logic [15:0]         s_job_id,
    input  wire logic [31:0]         s_duration,
    input  wire logic                s_cyclic,
    input  wire mstt_pkg::mstt_cmd_t cmd,
    output mstt_pkg::mstt_sts_t      sts,
    input  wire logic                emit_status,
    input  wire logic                emit_expiry,
    input  wire logic                emit_idle,
    output logic                     out_free,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [1:0]               m_kind,
    output logic                     m_ok,
    output logic                     m_running,
    output logic [15:0]              m_expired_id,
    output logic                     m_expired_cyclic,
    output logic                     m_last
);

    localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [PW-1:0] PTR_LAST = PW'(SLOTS - 1);
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    logic [SLOTS-1:0]     valid_reg;
    logic [ID_BITS-1:0]   ident_mem [SLOTS];
    logic [TIME_BITS-1:0] length_mem [SLOTS];
    logic [TIME_BITS-1:0] elapsed_mem [SLOTS];
    logic [SLOTS-1:0]     reload_reg;

    logic [2:0]           op_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [TIME_BITS-1:0] dur_reg;
    logic                 cyc_reg;
    logic [PW-1:0]        ptr_reg;
    logic                 found_reg, free_reg;
    logic [PW-1:0]        found_idx_reg, free_idx_reg;

    logic                 out_valid_reg;

    logic                 cur_valid, cur_match, expire;
    logic [TIME_BITS-1:0] cur_elapsed, inc_elapsed;
    logic                 ok_cmd, run_cmd;

    assign cur_valid   = valid_reg[ptr_reg];
    assign cur_elapsed = elapsed_mem[ptr_reg];
    assign cur_match   = cur_valid && (ident_mem[ptr_reg] == id_reg);
    assign inc_elapsed = (cur_elapsed == TMAX) ? cur_elapsed
                                               : cur_elapsed + TIME_BITS'(1);
    assign expire      = cur_valid && (inc_elapsed >= length_mem[ptr_reg]);

    assign sts.scan_last = (ptr_reg == PTR_LAST);
    assign sts.expire    = expire;
    assign sts.tick_op   = (op_reg == mstt_pkg::OP_TICK);

    // Command outcome from the search pass
    always_comb begin
        ok_cmd  = 1'b0;
        run_cmd = 1'b0;
        unique case (op_reg)
            mstt_pkg::OP_START:   ok_cmd = found_reg || free_reg;
            mstt_pkg::OP_RESTART,
            mstt_pkg::OP_STOP,
            mstt_pkg::OP_CYCLIC:  ok_cmd = found_reg;
            mstt_pkg::OP_QUERY: begin
                ok_cmd  = found_reg;
                run_cmd = found_reg;
            end
            default: ok_cmd = 1'b0;
        endcase
    end

    // Capture request, walk pointer and record search hits
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_operation;
            id_reg  <= ID_BITS'(s_job_id);
            dur_reg <= TIME_BITS'(s_duration);
            cyc_reg <= s_cyclic;
        end
        if (cmd.clr_scan) begin
            ptr_reg   <= '0;
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
        end else if (cmd.step) begin
            ptr_reg <= (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PW'(1);
        end
        if (cmd.scan) begin
            if (cur_match && !found_reg) begin
                found_reg     <= 1'b1;
                found_idx_reg <= ptr_reg;
            end
            if (!cur_valid && !free_reg) begin
                free_reg     <= 1'b1;
                free_idx_reg <= ptr_reg;
            end
        end
    end

    // Slot store updates
    always_ff @(posedge aclk) begin
        if (cmd.tick && cur_valid) begin
            if (expire && reload_reg[ptr_reg]) elapsed_mem[ptr_reg] <= '0;
            else                               elapsed_mem[ptr_reg] <= inc_elapsed;
        end
        if (cmd.apply && op_reg == mstt_pkg::OP_START && found_reg) begin
            length_mem[found_idx_reg]  <= dur_reg;
            elapsed_mem[found_idx_reg] <= '0;
        end else if (cmd.apply && op_reg == mstt_pkg::OP_START && free_reg) begin
            ident_mem[free_idx_reg]   <= id_reg;
            length_mem[free_idx_reg]  <= dur_reg;
            elapsed_mem[free_idx_reg] <= '0;
        end else if (cmd.apply && op_reg == mstt_pkg::OP_RESTART && found_reg) begin
            elapsed_mem[found_idx_reg] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (cmd.tick && expire && !reload_reg[ptr_reg]) valid_reg[ptr_reg] <= 1'b0;
            if (cmd.apply && op_reg == mstt_pkg::OP_START && found_reg) begin
                reload_reg[found_idx_reg] <= cyc_reg;
            end else if (cmd.apply && op_reg == mstt_pkg::OP_START && free_reg) begin
                valid_reg[free_idx_reg]  <= 1'b1;
                reload_reg[free_idx_reg] <= cyc_reg;
            end else if (cmd.apply && op_reg == mstt_pkg::OP_STOP && found_reg) begin
                valid_reg[found_idx_reg] <= 1'b0;
            end else if (cmd.apply && op_reg == mstt_pkg::OP_CYCLIC && found_reg) begin
                reload_reg[found_idx_reg] <= cyc_reg;
            end
        end
    end

    // Output register; each expiry of a tick is held until the next one or
    // the end of the walk, so the final one can carry the last flag
    logic                hold_reg;
    logic [ID_BITS-1:0]  hold_id_reg;
    logic                hold_cyc_reg;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            hold_reg      <= 1'b0;
        end else begin
            if (emit_expiry && hold_reg) begin
                // a further expiry: send the held one without the last flag
                out_valid_reg    <= 1'b1;
                m_kind           <= mstt_pkg::KIND_EXPIRY;
                m_ok             <= 1'b1;
                m_running        <= 1'b0;
                m_expired_id     <= 16'(hold_id_reg);
                m_expired_cyclic <= hold_cyc_reg;
                m_last           <= 1'b0;
            end else if (emit_status && hold_reg) begin
                // end of the walk: send the held expiry as the final result
                out_valid_reg    <= 1'b1;
                m_kind           <= mstt_pkg::KIND_EXPIRY;
                m_ok             <= 1'b1;
                m_running        <= 1'b0;
                m_expired_id     <= 16'(hold_id_reg);
                m_expired_cyclic <= hold_cyc_reg;
                m_last           <= 1'b1;
            end else if (emit_status || emit_idle) begin
                out_valid_reg    <= 1'b1;
                m_kind           <= emit_idle ? mstt_pkg::KIND_IDLE : mstt_pkg::KIND_STATUS;
                m_ok             <= emit_idle ? 1'b1 : ok_cmd;
                m_running        <= emit_idle ? 1'b0 : run_cmd;
                m_expired_id     <= '0;
                m_expired_cyclic <= 1'b0;
                m_last           <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            // Hold the current expiry; drop the hold once flushed
            if (emit_expiry) begin
                hold_reg     <= 1'b1;
                hold_id_reg  <= ident_mem[ptr_reg];
                hold_cyc_reg <= reload_reg[ptr_reg];
            end else if (emit_status && hold_reg) begin
                hold_reg <= 1'b0;
            end
        end
    end

    // An expiry is only reported for an active slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tick && expire |-> cur_valid)
        else $error("expiry on empty slot");
    // Apply never runs during a tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply |-> op_reg != mstt_pkg::OP_TICK)
        else $error("apply on tick");
    // A stalled result stays valid with its kind unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind))
        else $error("stalled result lost");

endmodule
`default_nettype wire

// ===== src/multi_slot_timer_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_slot_timer_table
// Table of SLOTS one-shot or periodic timers addressed by identifier.
//
// Requests arrive on s_valid/s_ready with operation, job_id, duration and
// cyclic. Results leave on m_valid/m_ready, one per command, or one per
// expiring timer on a tick (a single idle result when none expire); m_last
// marks the final result of a request.
// A command walks all slots, one per cycle, to find its identifier and the
// lowest free slot, then applies and registers its result once the output
// register is free. A tick first passes through the scan state, then walks
// the slots once, one per cycle unless stalled, updating each in place.
// Each expiry is held until the next one or the end of the walk so the
// final one can be marked.
// A new request is taken only once the previous one is finished.
// When the receiver stalls, the walk pauses on an expiry that finds the
// output register still full, and resumes when it frees.
// Synchronous reset empties the table and the output register.
// ----------------------------------------------------------------------------
module multi_slot_timer_table #(
    parameter int SLOTS     = mstt_pkg::SLOTS_DEF,
    parameter int ID_BITS   = mstt_pkg::ID_BITS_DEF,
    parameter int TIME_BITS = mstt_pkg::TIME_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_operation,
    input  wire logic [15:0] s_job_id,
    input  wire logic [31:0] s_duration,
    input  wire logic        s_cyclic,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic             m_ok,
    output logic             m_running,
    output logic [15:0]      m_expired_id,
    output logic             m_expired_cyclic,
    output logic             m_last
);

    mstt_pkg::mstt_cmd_t cmd;
    mstt_pkg::mstt_sts_t sts;
    logic out_free, emit_status, emit_expiry, emit_idle;

    mstt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .out_free(out_free), .sts(sts), .cmd(cmd),
        .emit_status(emit_status), .emit_expiry(emit_expiry),
        .emit_idle(emit_idle)
    );

    mstt_path #(.SLOTS(SLOTS), .ID_BITS(ID_BITS), .TIME_BITS(TIME_BITS)) u_path (
        .aclk(aclk), .aresetn(aresetn),
        .s_operation(s_operation), .s_job_id(s_job_id),
        .s_duration(s_duration), .s_cyclic(s_cyclic),
        .cmd(cmd), .sts(sts),
        .emit_status(emit_status), .emit_expiry(emit_expiry),
        .emit_idle(emit_idle), .out_free(out_free),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind), .m_ok(m_ok),
        .m_running(m_running), .m_expired_id(m_expired_id),
        .m_expired_cyclic(m_expired_cyclic), .m_last(m_last)
    );

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the timer table: directed command and tick sequences, then
// random traffic, all checked against an in-bench model of the slot table.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NSLOT = 16;
    localparam logic [2:0] OP_BAD6 = 3'd6;
    localparam logic [2:0] OP_BAD7 = 3'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic        ok;
        logic        running;
        logic [15:0] expired_id;
        logic        expired_cyclic;
        logic        last;
    } timer_result_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [2:0] s_operation;
    logic [15:0] s_job_id;
    logic [31:0] s_duration;
    logic s_cyclic;
    logic m_valid;
    logic m_ready;
    logic [1:0] m_kind;
    logic m_ok;
    logic m_running;
    logic [15:0] m_expired_id;
    logic m_expired_cyclic;
    logic m_last;

    // table model
    logic        tbl_used   [NSLOT];
    logic [15:0] tbl_id     [NSLOT];
    logic [31:0] tbl_len    [NSLOT];
    logic [31:0] tbl_count  [NSLOT];
    logic        tbl_reload [NSLOT];

    timer_result_t pending_results[$];
    int n_errors;
    int n_requests;
    int n_results;
    int n_expiries;
    bit random_stall;

    multi_slot_timer_table u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_job_id(s_job_id), .s_duration(s_duration), .s_cyclic(s_cyclic),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind), .m_ok(m_ok),
        .m_running(m_running), .m_expired_id(m_expired_id),
        .m_expired_cyclic(m_expired_cyclic), .m_last(m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hard stop
    initial begin
        #20ms;
        $display("timeout waiting for the design");
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int lookup_slot(input logic [15:0] id);
        for (int i = 0; i < NSLOT; i++)
            if (tbl_used[i] && tbl_id[i] == id) return i;
        return -1;
    endfunction

    // Append one expected result
    function automatic void queue_result(input timer_result_t r);
        pending_results = {pending_results, r};
    endfunction

    // Work out the results of one request and update the table
    function automatic void predict_request(input logic [2:0] op, input logic [15:0] id,
                                            input logic [31:0] dur, input logic cyc);
        timer_result_t r;
        int slot;
        int hits;
        r = '0;
        if (op == mstt_pkg::OP_TICK) begin
            hits = 0;
            for (int i = 0; i < NSLOT; i++) begin
                if (!tbl_used[i]) continue;
                if (tbl_count[i] != 32'hFFFF_FFFF) tbl_count[i] = tbl_count[i] + 32'd1;
                if (tbl_count[i] >= tbl_len[i]) begin
                    r = '0;
                    r.kind = mstt_pkg::KIND_EXPIRY;
                    r.ok = 1'b1;
                    r.expired_id = tbl_id[i];
                    r.expired_cyclic = tbl_reload[i];
                    queue_result(r);
                    hits++;
                    if (tbl_reload[i]) tbl_count[i] = '0;
                    else tbl_used[i] = 1'b0;
                end
            end
            if (hits == 0) begin
                r = '0;
                r.kind = mstt_pkg::KIND_IDLE;
                r.ok = 1'b1;
                r.last = 1'b1;
                queue_result(r);
            end else begin
                pending_results[$].last = 1'b1;
            end
            return;
        end
        slot = lookup_slot(id);
        r.kind = mstt_pkg::KIND_STATUS;
        r.last = 1'b1;
        case (op)
            mstt_pkg::OP_START: begin
                if (slot < 0)
                    for (int i = 0; i < NSLOT; i++)
                        if (!tbl_used[i]) begin
                            slot = i;
                            break;
                        end
                if (slot >= 0) begin
                    tbl_used[slot] = 1'b1;
                    tbl_id[slot] = id;
                    tbl_len[slot] = dur;
                    tbl_count[slot] = '0;
                    tbl_reload[slot] = cyc;
                    r.ok = 1'b1;
                end
            end
            mstt_pkg::OP_RESTART: if (slot >= 0) begin
                tbl_count[slot] = '0;
                r.ok = 1'b1;
            end
            mstt_pkg::OP_STOP: if (slot >= 0) begin
                tbl_used[slot] = 1'b0;
                r.ok = 1'b1;
            end
            mstt_pkg::OP_CYCLIC: if (slot >= 0) begin
                tbl_reload[slot] = cyc;
                r.ok = 1'b1;
            end
            mstt_pkg::OP_QUERY: if (slot >= 0) begin
                r.ok = 1'b1;
                r.running = 1'b1;
            end
            default: ;
        endcase
        queue_result(r);
    endfunction

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Send one request with a random gap in front
    task automatic send_request(input logic [2:0] op, input logic [15:0] id,
                                input logic [31:0] dur, input logic cyc);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) gap = 1;
        repeat (gap) @(posedge aclk);
        s_valid <= 1'b1;
        s_operation <= op;
        s_job_id <= id;
        s_duration <= dur;
        s_cyclic <= cyc;
        do @(posedge aclk); while (!s_ready);
        predict_request(op, id, dur, cyc);
        n_requests++;
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (NSLOT + 8) @(posedge aclk);
    endtask

    // Stall the result side at random
    always @(posedge aclk) begin
        if (!aresetn || !random_stall) m_ready <= 1'b1;
        else if ($urandom_range(0, 39) == 0) m_ready <= 1'b0;
        else if ($urandom_range(0, 2) != 0) m_ready <= 1'b1;
    end

    // Check each result against the oldest expectation
    always @(posedge aclk) begin
        timer_result_t got;
        timer_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_kind, m_ok, m_running, m_expired_id, m_expired_cyclic, m_last};
            n_results++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with none expected");
            end else begin
                exp_r = pending_results.pop_front();
                if (exp_r.kind == mstt_pkg::KIND_EXPIRY) n_expiries++;
                if (got.kind != exp_r.kind)
                    report_mismatch($sformatf("kind %0d exp %0d", got.kind, exp_r.kind));
                if (got.ok != exp_r.ok)
                    report_mismatch($sformatf("ok %0d exp %0d", got.ok, exp_r.ok));
                if (got.running != exp_r.running)
                    report_mismatch($sformatf("running %0d exp %0d", got.running,
                                              exp_r.running));
                if (got.expired_id != exp_r.expired_id)
                    report_mismatch($sformatf("expired_id %h exp %h", got.expired_id,
                                              exp_r.expired_id));
                if (got.expired_cyclic != exp_r.expired_cyclic)
                    report_mismatch($sformatf("expired_cyclic %0d exp %0d",
                                              got.expired_cyclic, exp_r.expired_cyclic));
                if (got.last != exp_r.last)
                    report_mismatch($sformatf("last %0d exp %0d", got.last, exp_r.last));
            end
        end
    end

    // Directed: every operation, extremes, full table, zero length
    task automatic test_directed();
        send_request(mstt_pkg::OP_QUERY, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(mstt_pkg::OP_RESTART, 16'h0000, '0, 1'b0);
        send_request(mstt_pkg::OP_STOP, 16'h1234, '0, 1'b0);
        send_request(mstt_pkg::OP_CYCLIC, 16'h1234, '0, 1'b1);
        send_request(mstt_pkg::OP_TICK, '0, '0, 1'b0);
        send_request(mstt_pkg::OP_START, 16'h0000, 32'd0, 1'b0);
        send_request(mstt_pkg::OP_START, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(mstt_pkg::OP_START, 16'h00A5, 32'd0, 1'b1);
        send_request(mstt_pkg::OP_QUERY, 16'hFFFF, '0, 1'b0);
        send_request(mstt_pkg::OP_TICK, '0, '0, 1'b0);
        send_request(mstt_pkg::OP_START, 16'h00A5, 32'd2, 1'b0);
        send_request(mstt_pkg::OP_CYCLIC, 16'h00A5, '0, 1'b1);
        send_request(mstt_pkg::OP_RESTART, 16'hFFFF, '0, 1'b0);
        send_request(mstt_pkg::OP_TICK, '0, '0, 1'b0);
        send_request(mstt_pkg::OP_TICK, '0, '0, 1'b0);
        send_request(mstt_pkg::OP_STOP, 16'hFFFF, '0, 1'b0);
        send_request(OP_BAD6, 16'h00A5, '0, 1'b1);
        send_request(OP_BAD7, 16'hFFFF, '1, 1'b0);
        // fill, overflow, then replace in a full table
        for (int i = 0; i < NSLOT + 1; i++)
            send_request(mstt_pkg::OP_START, 16'(16'h0100 + i), 32'(i % 4), 1'(i));
        send_request(mstt_pkg::OP_START, 16'h0100, 32'd1, 1'b0);
        send_request(mstt_pkg::OP_TICK, '0, '0, 1'b0);
        send_request(mstt_pkg::OP_TICK, '0, '0, 1'b0);
        // hold off until the table has answered everything
        wait_drained();
    endtask

    function automatic logic [15:0] pick_id();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7) return 16'($urandom_range(0, 23));
        if (k == 7) return 16'($urandom_range(16'hFFF0, 16'hFFFF));
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_dur();
        int k;
        k = $urandom_range(0, 19);
        if (k < 16) return 32'($urandom_range(0, 6));
        if (k < 18) return 32'hFFFF_FFFF - 32'($urandom_range(0, 2));
        return 32'($urandom);
    endfunction

    // Random: mostly ticks and starts over a small identifier pool
    task automatic test_random();
        int k;
        logic [2:0] op;
        random_stall = 1'b1;
        for (int n = 0; n < 210; n++) begin
            k = $urandom_range(0, 99);
            if (k < 30) op = mstt_pkg::OP_TICK;
            else if (k < 55) op = mstt_pkg::OP_START;
            else if (k < 63) op = mstt_pkg::OP_RESTART;
            else if (k < 73) op = mstt_pkg::OP_STOP;
            else if (k < 81) op = mstt_pkg::OP_CYCLIC;
            else if (k < 97) op = mstt_pkg::OP_QUERY;
            else op = 3'($urandom_range(6, 7));
            send_request(op, pick_id(), pick_dur(), 1'($urandom));
            if (n == 105) wait_drained();
        end
    endtask

    initial begin
        n_errors = 0;
        n_requests = 0;
        n_results = 0;
        n_expiries = 0;
        random_stall = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = '0;
        s_job_id = '0;
        s_duration = '0;
        s_cyclic = 1'b0;
        m_ready = 1'b1;
        for (int i = 0; i < NSLOT; i++) tbl_used[i] = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        wait_drained();
        $display("covered %0d requests, %0d results, %0d timer expiries",
                 n_requests, n_results, n_expiries);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/mstt_pkg.sv
src/mstt_ctrl.sv
src/mstt_path.sv
src/multi_slot_timer_table.sv
dv/tb_top.sv
